/* design/mrwt_pkg.sv */
// Package for the Miller-Rabin witness test unit.
// Widths, controller commands and status; no dependencies.
package mrwt_pkg;

  localparam int NUMBER_BITS = 64;
  localparam int CNT_BITS    = $clog2(NUMBER_BITS + 1);

  typedef logic [NUMBER_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  // Datapath operations, one per controller step
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_LOAD    = 3'd1,  // latch n, a; set d = n-1, r = 0
    OP_STRIP   = 3'd2,  // d >>= 1, r++
    OP_REDUCE  = 3'd3,  // one bit of a mod n
    OP_MUL     = 3'd4,  // one bit of modular multiply
    OP_MULDONE = 3'd5,  // commit product to destination
    OP_SETUP   = 3'd6   // choose operands for next multiply
  } op_t;

  // Destination of a modular multiply
  typedef enum logic [1:0] {
    DST_X    = 2'd0,
    DST_BASE = 2'd1
  } dst_t;

  typedef struct packed {
    op_t  op;
    dst_t dst;
    logic sq_x;    // operands x*x rather than x*base / base*base
  } dp_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_lt4;
    logic n_even;
    logic d_even;
    logic r_full;
    logic e_zero;
    logic e_lsb;
    logic x_one;
    logic x_nm1;
    logic r_left;   // more squarings allowed (j < r)
    logic bit_done; // bit counter at last bit
  } dp_sts_t;

endpackage

/* design/miller_rabin_witness_test_unit.sv */
// Miller-Rabin witness test unit: one round per item, AND over a group.
// Numbers below 4 or even are settled in the check step; otherwise set-up
// (strip, bit-serial reduction of the witness mod n) precedes the modular
// multiplies, at most 126, all on the one bit-serial multiplier.
// Throughput: one item at a time; input stalls until the round completes.
// Reset (synchronous, rst_n low): idle, group flag one, no result pending.
module miller_rabin_witness_test_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mrwt_pkg::word_t        in_number,
  input  mrwt_pkg::word_t        in_witness,
  input  logic                   in_last_witness,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_probably_prime
);

  mrwt_pkg::dp_cmd_t cmd;
  mrwt_pkg::dp_sts_t sts;

  mrwt_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_last_witness    (in_last_witness),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_probably_prime (out_probably_prime),
    .sts                (sts),
    .cmd                (cmd)
  );

  mrwt_datapath u_dp (
    .clk        (clk),
    .in_number  (in_number),
    .in_witness (in_witness),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

/* design/mrwt_datapath.sv */
// Datapath: operand registers, bit-serial modular multiplier and reducer.
// Depends on mrwt_pkg.
module mrwt_datapath (
  input  logic              clk,
  input  mrwt_pkg::word_t   in_number,
  input  mrwt_pkg::word_t   in_witness,
  input  mrwt_pkg::dp_cmd_t cmd,
  output mrwt_pkg::dp_sts_t sts
);

  mrwt_pkg::word_t n_r, nm1_r, d_r, e_r, base_r, x_r, acc_r, mx_r, my_r, a_r;
  mrwt_pkg::cnt_t  r_r, j_r, bit_r;

  // acc doubled mod n, then plus mx if bit set
  mrwt_pkg::word_t dbl, add_in, sum;
  logic [mrwt_pkg::NUMBER_BITS:0] dbl_w, sum_w, rem_w;

  always_comb begin
    dbl_w  = {acc_r, 1'b0};
    dbl    = (dbl_w >= {1'b0, n_r}) ? mrwt_pkg::word_t'(dbl_w - {1'b0, n_r})
                                    : dbl_w[mrwt_pkg::NUMBER_BITS-1:0];
    add_in = my_r[mrwt_pkg::NUMBER_BITS-1] ? mx_r : '0;
    sum_w  = {1'b0, dbl} + {1'b0, add_in};
    sum    = (sum_w >= {1'b0, n_r}) ? mrwt_pkg::word_t'(sum_w - {1'b0, n_r})
                                    : sum_w[mrwt_pkg::NUMBER_BITS-1:0];
    // restoring reduction step: rem = acc*2 + next bit of a
    rem_w  = {acc_r, a_r[mrwt_pkg::NUMBER_BITS-1]};
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mrwt_pkg::OP_LOAD: begin
        n_r    <= in_number;
        nm1_r  <= in_number - 1'b1;
        d_r    <= in_number - 1'b1;
        a_r    <= in_witness;
        r_r    <= '0;
        j_r    <= mrwt_pkg::cnt_t'(1);
        acc_r  <= '0;
        bit_r  <= '0;
        x_r    <= mrwt_pkg::word_t'(1);
      end
      mrwt_pkg::OP_STRIP: begin
        d_r <= d_r >> 1;
        r_r <= r_r + 1'b1;
      end
      mrwt_pkg::OP_REDUCE: begin
        acc_r <= (rem_w >= {1'b0, n_r}) ? mrwt_pkg::word_t'(rem_w - {1'b0, n_r})
                                        : rem_w[mrwt_pkg::NUMBER_BITS-1:0];
        a_r   <= a_r << 1;
        bit_r <= bit_r + 1'b1;
        if (bit_r == mrwt_pkg::cnt_t'(mrwt_pkg::NUMBER_BITS - 1)) begin
          e_r <= d_r;
        end
      end
      mrwt_pkg::OP_SETUP: begin
        bit_r <= '0;
        if (cmd.sq_x) begin
          mx_r <= x_r;
          my_r <= x_r;
        end else if (cmd.dst == mrwt_pkg::DST_X) begin
          mx_r <= x_r;
          my_r <= base_r;
        end else begin
          mx_r <= base_r;
          my_r <= base_r;
        end
        acc_r <= '0;
      end
      mrwt_pkg::OP_MUL: begin
        acc_r <= sum;
        my_r  <= my_r << 1;
        bit_r <= bit_r + 1'b1;
      end
      mrwt_pkg::OP_MULDONE: begin
        if (cmd.sq_x) begin
          x_r <= acc_r;
          j_r <= j_r + 1'b1;
        end else if (cmd.dst == mrwt_pkg::DST_X) begin
          x_r <= acc_r;
        end else begin
          base_r <= acc_r;
          e_r    <= e_r >> 1;
        end
      end
      default: begin
        // base register takes the reduced witness once reduction ends
        if (bit_r == mrwt_pkg::cnt_t'(mrwt_pkg::NUMBER_BITS)) begin
          base_r <= acc_r;
          bit_r  <= '0;
        end
      end
    endcase
  end

  always_comb begin
    sts.n_lt2    = (n_r < mrwt_pkg::word_t'(2));
    sts.n_lt4    = (n_r < mrwt_pkg::word_t'(4));
    sts.n_even   = ~n_r[0];
    sts.d_even   = ~d_r[0];
    sts.r_full   = (r_r == mrwt_pkg::cnt_t'(mrwt_pkg::NUMBER_BITS));
    sts.e_zero   = (e_r == '0);
    sts.e_lsb    = e_r[0];
    sts.x_one    = (x_r == mrwt_pkg::word_t'(1));
    sts.x_nm1    = (x_r == nm1_r);
    sts.r_left   = (j_r < r_r);
    sts.bit_done = (bit_r == mrwt_pkg::cnt_t'(mrwt_pkg::NUMBER_BITS - 1));
  end

endmodule

/* design/mrwt_ctrl.sv */
// Controller state machine: sequences one Miller-Rabin round, keeps the
// group flag and the output register. Depends on mrwt_pkg.
module mrwt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_last_witness,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_probably_prime,
  input  mrwt_pkg::dp_sts_t sts,
  output mrwt_pkg::dp_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CHECK  = 10'b0000000010,
    S_STRIP  = 10'b0000000100,
    S_REDUCE = 10'b0000001000,
    S_HOLD   = 10'b0000010000,
    S_PICK   = 10'b0000100000,
    S_MUL    = 10'b0001000000,
    S_COMMIT = 10'b0010000000,
    S_SQUARE = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t       state_r, state_nxt;
  logic         pass_r, pass_nxt;
  logic         last_r, last_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic         oprime_r, oprime_nxt;
  logic         sq_r, sq_nxt;       // current multiply squares x
  mrwt_pkg::dst_t dst_r, dst_nxt;
  logic         res_pass;          // round outcome while in S_DONE
  logic         res_r, res_nxt;

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = ovalid_r;
  assign out_probably_prime = oprime_r;

  always_comb begin
    state_nxt  = state_r;
    pass_nxt   = pass_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r & out_stall;
    oprime_nxt = oprime_r;
    sq_nxt     = sq_r;
    dst_nxt    = dst_r;
    res_nxt    = res_r;
    res_pass   = 1'b0;
    cmd.op     = mrwt_pkg::OP_NONE;
    cmd.dst    = dst_r;
    cmd.sq_x   = sq_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = mrwt_pkg::OP_LOAD;
          last_nxt  = in_last_witness;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.n_lt2) begin
          res_nxt = 1'b0; state_nxt = S_DONE;
        end else if (sts.n_lt4) begin
          res_nxt = 1'b1; state_nxt = S_DONE;
        end else if (sts.n_even) begin
          res_nxt = 1'b0; state_nxt = S_DONE;
        end else begin
          state_nxt = S_STRIP;
        end
      end
      S_STRIP: begin
        if (sts.d_even && !sts.r_full) begin
          cmd.op = mrwt_pkg::OP_STRIP;
        end else begin
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.op = mrwt_pkg::OP_REDUCE;
        if (sts.bit_done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        // default op commits reduced base
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (sts.e_zero) begin
          // x = 1 only passes before the first squaring
          if (sts.x_nm1 || (sts.x_one && !sq_r)) begin
            res_nxt = 1'b1; state_nxt = S_DONE;
          end else if (sts.r_left) begin
            sq_nxt = 1'b1; state_nxt = S_SQUARE;
          end else begin
            res_nxt = 1'b0; state_nxt = S_DONE;
          end
        end else begin
          sq_nxt    = 1'b0;
          dst_nxt   = sts.e_lsb ? mrwt_pkg::DST_X : mrwt_pkg::DST_BASE;
          cmd.op    = mrwt_pkg::OP_SETUP;
          cmd.dst   = dst_nxt;
          cmd.sq_x  = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_SQUARE: begin
        cmd.op    = mrwt_pkg::OP_SETUP;
        cmd.sq_x  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op = mrwt_pkg::OP_MUL;
        if (sts.bit_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.op = mrwt_pkg::OP_MULDONE;
        if (sq_r) begin
          state_nxt = S_PICK;   // re-test x after the square
        end else if (dst_r == mrwt_pkg::DST_X) begin
          // x updated; now square the base for this bit
          dst_nxt   = mrwt_pkg::DST_BASE;
          state_nxt = S_HOLD;
        end else begin
          state_nxt = S_PICK;
        end
      end
      S_DONE: begin
        res_pass = res_r;
        if (!ovalid_r || !out_stall || !last_r) begin
          if (last_r) begin
            ovalid_nxt = 1'b1;
            oprime_nxt = pass_r & res_pass;
            pass_nxt   = 1'b1;
          end else begin
            pass_nxt = pass_r & res_pass;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // after x = x*base the same bit squares base: reuse S_HOLD as a hop into a
    // base setup
    // S_HOLD after reduction uses dst reset to DST_X; after x commit dst is BASE
    if (state_r == S_HOLD && dst_r == mrwt_pkg::DST_BASE && !sq_r &&
        !sts.e_zero) begin
      cmd.op    = mrwt_pkg::OP_SETUP;
      cmd.dst   = mrwt_pkg::DST_BASE;
      cmd.sq_x  = 1'b0;
      state_nxt = S_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pass_r   <= 1'b1;
      ovalid_r <= 1'b0;
      dst_r    <= mrwt_pkg::DST_X;
      sq_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pass_r   <= pass_nxt;
      ovalid_r <= ovalid_nxt;
      dst_r    <= (state_nxt == S_CHECK) ? mrwt_pkg::DST_X : dst_nxt;
      sq_r     <= sq_nxt;
    end
    last_r   <= last_nxt;
    oprime_r <= oprime_nxt;
    res_r    <= res_nxt;
  end

endmodule
